// ----- sv/clock_page_replacement_core_macros.svh -----
// Assertion macros shared by the clock page replacement checker.
`ifndef CLOCK_PAGE_REPLACEMENT_CORE_MACROS_SVH
`define CLOCK_PAGE_REPLACEMENT_CORE_MACROS_SVH

// Same-cycle implication, held off while reset is low.
`define CPR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is low.
`define CPR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/cpr_pkg.sv -----
// Shared constants and controller/datapath command and status types.
package cpr_pkg;

    localparam int CNT_W = 32;
    localparam int CFG_W = 5;
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    typedef struct packed {
        logic start;
        logic scan;
        logic ev_read;
        logic hit_commit;
        logic miss_commit;
        logic ev_commit;
    } t_cmd;

    typedef struct packed {
        logic match;
        logic scan_done;
        logic full;
        logic out_free;
    } t_status;

endpackage

// ----- sv/cpr_ifs.sv -----
// Request and response channel interfaces.
interface cpr_req_if #(
    parameter int PAGE_BITS = 32
);
    logic                 valid;
    logic                 ready;
    logic [PAGE_BITS-1:0] page_number;

    modport source (output valid, output page_number, input ready);
    modport sink   (input valid, input page_number, output ready);
endinterface

interface cpr_rsp_if #(
    parameter int PAGE_BITS = 32,
    parameter int IDX_BITS  = 4
);
    import cpr_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic [IDX_BITS-1:0]  slot_index;
    logic                 evicted;
    logic [PAGE_BITS-1:0] evicted_page;
    logic [CNT_W-1:0]     hits_so_far;
    logic [CNT_W-1:0]     misses_so_far;

    modport source (output valid, output hit, output slot_index, output evicted,
                    output evicted_page, output hits_so_far, output misses_so_far,
                    input ready);
    modport sink   (input valid, input hit, input slot_index, input evicted,
                    input evicted_page, input hits_so_far, input misses_so_far,
                    output ready);
endinterface

// ----- sv/cpr_ctrl.sv -----
// Sequencing state machine for lookup, sweep, eviction and commit.
module cpr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  cpr_pkg::t_status i_status,
    output cpr_pkg::t_cmd    o_cmd
);
    import cpr_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_HIT   = 6'b000100,
        S_MISS  = 6'b001000,
        S_EVRD  = 6'b010000,
        S_EVICT = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.match) begin
                    n_state = S_HIT;
                end else if (i_status.scan_done) begin
                    n_state = i_status.full ? S_EVRD : S_MISS;
                end
            end
            S_HIT: begin
                if (i_status.out_free) begin
                    o_cmd.hit_commit = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_MISS: begin
                if (i_status.out_free) begin
                    o_cmd.miss_commit = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_EVRD: begin
                o_cmd.ev_read = 1'b1;
                n_state       = S_EVICT;
            end
            S_EVICT: begin
                if (i_status.out_free) begin
                    o_cmd.ev_commit = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_req_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- sv/cpr_dpath.sv -----
// Page memory, reference and valid bits, clock hand, counters and result register.
module cpr_dpath #(
    parameter int SLOT_COUNT = 16,
    parameter int PAGE_BITS  = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [PAGE_BITS-1:0]                 i_page,
    input  logic                                 i_cfg_we,
    input  logic [cpr_pkg::CFG_W-1:0]            i_cfg_wdata,
    input  cpr_pkg::t_cmd                        i_cmd,
    output cpr_pkg::t_status                     o_status,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic                                 o_hit,
    output logic [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1)-1:0] o_slot_index,
    output logic                                 o_evicted,
    output logic [PAGE_BITS-1:0]                 o_evicted_page,
    output logic [cpr_pkg::CNT_W-1:0]            o_hits_so_far,
    output logic [cpr_pkg::CNT_W-1:0]            o_misses_so_far
);
    import cpr_pkg::*;

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam int CAP_RESET = (int'(CFG_RESET) > SLOT_COUNT) ? SLOT_COUNT : int'(CFG_RESET);

    logic [PAGE_BITS-1:0]  r_mem [SLOT_COUNT];
    logic [PAGE_BITS-1:0]  r_page;
    logic [PAGE_BITS-1:0]  r_rd_data;
    logic                  r_rd_vld;
    logic [IW-1:0]         r_rd_idx;
    logic [CW-1:0]         r_scan;
    logic [IW-1:0]         r_hand;
    logic [IW-1:0]         r_ptr;
    logic [CW-1:0]         r_sw_cnt;
    logic                  r_sw_done;
    logic                  r_wrap;
    logic [IW-1:0]         r_slot;
    logic [SLOT_COUNT-1:0] r_valid;
    logic [SLOT_COUNT-1:0] r_ref;
    logic [CW-1:0]         r_occ;
    logic [CW-1:0]         r_cap;
    logic [CNT_W-1:0]      r_hits;
    logic [CNT_W-1:0]      r_misses;
    logic                  r_o_vld;
    logic                  r_o_hit;
    logic [IW-1:0]         r_o_slot;
    logic                  r_o_ev;
    logic [PAGE_BITS-1:0]  r_o_evpage;
    logic [CNT_W-1:0]      r_o_hits;
    logic [CNT_W-1:0]      r_o_misses;

    logic                  w_match;
    logic                  w_scan_live;
    logic [IW-1:0]         w_hand_norm;
    logic [IW-1:0]         w_hand_inc;
    logic [IW-1:0]         w_ptr_inc;
    logic [SLOT_COUNT-1:0] w_in_rng;
    logic [SLOT_COUNT-1:0] w_ref_ev;
    logic [CW-1:0]         w_cap_new;
    logic [CNT_W-1:0]      w_hits_inc;
    logic [CNT_W-1:0]      w_misses_inc;
    logic                  w_we;
    logic [IW-1:0]         w_wa;
    logic                  w_re;
    logic [IW-1:0]         w_ra;
    logic                  w_ev;

    assign w_scan_live  = (r_scan < r_cap);
    assign w_match      = r_rd_vld && r_valid[r_rd_idx] && (r_rd_data == r_page);
    assign w_hand_norm  = (CW'(r_hand) >= r_cap) ? '0 : r_hand;
    assign w_hand_inc   = ((CW'(r_hand) + CW'(1)) == r_cap) ? '0 : (r_hand + IW'(1));
    assign w_ptr_inc    = ((CW'(r_ptr) + CW'(1)) == r_cap) ? '0 : (r_ptr + IW'(1));
    assign w_hits_inc   = (r_hits == '1) ? r_hits : (r_hits + CNT_W'(1));
    assign w_misses_inc = (r_misses == '1) ? r_misses : (r_misses + CNT_W'(1));
    assign w_ev         = r_valid[r_ptr];

    // Clamp the written capacity into 1..SLOT_COUNT.
    always_comb begin
        if (i_cfg_wdata == '0) begin
            w_cap_new = CW'(1);
        end else if (int'(i_cfg_wdata) > SLOT_COUNT) begin
            w_cap_new = CW'(SLOT_COUNT);
        end else begin
            w_cap_new = CW'(i_cfg_wdata);
        end
    end

    // Slots the hand passed over on the way to the victim lose their bit.
    always_comb begin
        for (int k = 0; k < SLOT_COUNT; k++) begin
            if (r_wrap) begin
                w_in_rng[k] = 1'b1;
            end else if (r_hand <= r_ptr) begin
                w_in_rng[k] = (IW'(k) >= r_hand) && (IW'(k) < r_ptr);
            end else begin
                w_in_rng[k] = (IW'(k) >= r_hand) || (IW'(k) < r_ptr);
            end
            w_ref_ev[k] = r_ref[k] && !w_in_rng[k] && (IW'(k) != r_ptr);
        end
    end

    assign w_we = i_cmd.miss_commit || i_cmd.ev_commit;
    assign w_wa = i_cmd.ev_commit ? r_ptr : r_hand;
    assign w_re = (i_cmd.scan && w_scan_live) || i_cmd.ev_read;
    assign w_ra = i_cmd.ev_read ? r_ptr : r_scan[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= r_page;
        end
        if (w_re) begin
            r_rd_data <= r_mem[w_ra];
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_page <= i_page;
        end
        if (i_cmd.scan) begin
            r_rd_idx <= r_scan[IW-1:0];
            if (w_match) begin
                r_slot <= r_rd_idx;
            end
        end
        if (i_cmd.hit_commit) begin
            r_o_hit    <= 1'b1;
            r_o_slot   <= r_slot;
            r_o_ev     <= 1'b0;
            r_o_evpage <= '0;
            r_o_hits   <= w_hits_inc;
            r_o_misses <= r_misses;
        end
        if (i_cmd.miss_commit) begin
            r_o_hit    <= 1'b0;
            r_o_slot   <= r_hand;
            r_o_ev     <= 1'b0;
            r_o_evpage <= '0;
            r_o_hits   <= r_hits;
            r_o_misses <= w_misses_inc;
        end
        if (i_cmd.ev_commit) begin
            r_o_hit    <= 1'b0;
            r_o_slot   <= r_ptr;
            r_o_ev     <= w_ev;
            r_o_evpage <= w_ev ? r_rd_data : '0;
            r_o_hits   <= r_hits;
            r_o_misses <= w_misses_inc;
        end
    end

    // Control and policy state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld  <= 1'b0;
            r_scan    <= '0;
            r_hand    <= '0;
            r_ptr     <= '0;
            r_sw_cnt  <= '0;
            r_sw_done <= 1'b0;
            r_wrap    <= 1'b0;
            r_valid   <= '0;
            r_ref     <= '0;
            r_occ     <= '0;
            r_cap     <= CW'(CAP_RESET);
            r_hits    <= '0;
            r_misses  <= '0;
            r_o_vld   <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_rd_vld  <= 1'b0;
                r_scan    <= '0;
                r_hand    <= w_hand_norm;
                r_ptr     <= w_hand_norm;
                r_sw_cnt  <= '0;
                r_sw_done <= 1'b0;
                r_wrap    <= 1'b0;
            end
            if (i_cmd.scan) begin
                r_rd_vld <= w_scan_live;
                if (w_scan_live) begin
                    r_scan <= r_scan + CW'(1);
                end
                // Walk the hand alongside the tag scan; commit its path only on eviction.
                if (!r_sw_done) begin
                    if (!r_ref[r_ptr]) begin
                        r_sw_done <= 1'b1;
                    end else begin
                        r_ptr    <= w_ptr_inc;
                        r_sw_cnt <= r_sw_cnt + CW'(1);
                        if ((r_sw_cnt + CW'(1)) == r_cap) begin
                            r_sw_done <= 1'b1;
                            r_wrap    <= 1'b1;
                        end
                    end
                end
            end
            if (i_cmd.ev_read) begin
                r_rd_vld <= 1'b0;
            end
            if (i_cmd.hit_commit) begin
                r_ref[r_slot] <= 1'b1;
                r_hits        <= w_hits_inc;
            end
            if (i_cmd.miss_commit) begin
                r_valid[r_hand] <= 1'b1;
                r_ref[r_hand]   <= 1'b0;
                r_occ           <= r_occ + CW'(1);
                r_hand          <= w_hand_inc;
                r_misses        <= w_misses_inc;
            end
            if (i_cmd.ev_commit) begin
                r_valid[r_ptr] <= 1'b1;
                r_ref          <= w_ref_ev;
                if (!w_ev) begin
                    r_occ <= r_occ + CW'(1);
                end
                r_hand   <= w_ptr_inc;
                r_misses <= w_misses_inc;
            end
            if (i_cmd.hit_commit || i_cmd.miss_commit || i_cmd.ev_commit) begin
                r_o_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_o_vld <= 1'b0;
            end
            // Flush the store on a capacity write; keep the counters.
            if (i_cfg_we) begin
                r_valid <= '0;
                r_ref   <= '0;
                r_hand  <= '0;
                r_occ   <= '0;
                r_cap   <= w_cap_new;
            end
        end
    end

    assign o_status.match     = w_match;
    assign o_status.scan_done = (r_scan == r_cap) && !r_rd_vld;
    assign o_status.full      = (r_occ >= r_cap);
    assign o_status.out_free  = !r_o_vld || i_out_ready;

    assign o_out_valid     = r_o_vld;
    assign o_hit           = r_o_hit;
    assign o_slot_index    = r_o_slot;
    assign o_evicted       = r_o_ev;
    assign o_evicted_page  = r_o_evpage;
    assign o_hits_so_far   = r_o_hits;
    assign o_misses_so_far = r_o_misses;

endmodule

// ----- sv/clock_page_replacement_core.sv -----
// Top level of the clock (second chance) page replacement core.
//
//  Channel    Dir  Handshake            Payload
//  i_req      in   valid/ready          page_number
//  o_rsp      out  valid/ready          hit, slot_index, evicted, evicted_page,
//                                       hits_so_far, misses_so_far
//  i_cfg_*    in   write enable only    slots_in_use (5 bits)
//
// One request is in flight at a time. A hit ends the tag scan at its slot;
// a miss scans all capacity slots, and a miss that evicts also reads the
// victim's page, capacity being slots_in_use clamped into 1..SLOT_COUNT:
// the tag scan reads the page memory one slot per cycle, and the hand
// sweep runs beside it.
// Reset (synchronous, active low) empties the store and clears both counters.
// A result waits in the output register while o_rsp.ready is low; the next
// request is still taken and held before its commit until the register frees.
module clock_page_replacement_core #(
    parameter int SLOT_COUNT = 16,
    parameter int PAGE_BITS  = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    cpr_req_if.sink                   i_req,
    cpr_rsp_if.source                 o_rsp,
    input  logic                      i_cfg_we,
    input  logic [cpr_pkg::CFG_W-1:0] i_cfg_wdata
);
    import cpr_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // Sequence each request: scan, then hit, place or evict.
    cpr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // Hold the pages, policy bits, hand, counters and the registered result.
    cpr_dpath #(
        .SLOT_COUNT (SLOT_COUNT),
        .PAGE_BITS  (PAGE_BITS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_page          (i_req.page_number),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_out_ready     (o_rsp.ready),
        .o_out_valid     (o_rsp.valid),
        .o_hit           (o_rsp.hit),
        .o_slot_index    (o_rsp.slot_index),
        .o_evicted       (o_rsp.evicted),
        .o_evicted_page  (o_rsp.evicted_page),
        .o_hits_so_far   (o_rsp.hits_so_far),
        .o_misses_so_far (o_rsp.misses_so_far)
    );

endmodule

// ----- sv/cpr_checker.sv -----
// Port-level checks for the clock page replacement core, with its bind.
`include "clock_page_replacement_core_macros.svh"

module cpr_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic i_req_ready,
    input logic i_rsp_valid,
    input logic i_rsp_ready,
    input logic i_rsp_hit,
    input logic i_rsp_evicted
);

    `CPR_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid, "response dropped while stalled")
    `CPR_ASSERT_SAME(a_hit_no_evict, i_clk, i_rst_n, i_rsp_valid && i_rsp_hit, !i_rsp_evicted, "hit reported with an eviction")
    `CPR_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, i_req_valid && i_req_ready, !i_req_ready, "second request taken while busy")
    `CPR_ASSERT_NEXT(a_no_instant_rsp, i_clk, i_rst_n, i_req_valid && i_req_ready, !$rose(i_rsp_valid), "response raised before lookup")

endmodule

bind clock_page_replacement_core cpr_checker u_cpr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_hit     (o_rsp.hit),
    .i_rsp_evicted (o_rsp.evicted)
);

// ----- dv/tb_top.sv -----
// Self-checking testbench for the clock page replacement core.
module tb_top;

    import cpr_pkg::*;

    localparam int SLOTS          = 16;
    localparam int PAGE_W         = 32;
    localparam int IDX_W          = 4;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SQUEEZE_AFTER  = 400;   // requests taken before the long output stall
    localparam int SQUEEZE_CYCLES = 300;
    localparam int DRAIN_CYCLES   = SLOTS + 8;

    // One expected result per page reference.
    typedef struct packed {
        logic              hit;
        logic [IDX_W-1:0]  slot;
        logic              evicted;
        logic [PAGE_W-1:0] evicted_page;
        logic [CNT_W-1:0]  hits;
        logic [CNT_W-1:0]  misses;
    } t_page_result;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    cpr_req_if #(.PAGE_BITS(PAGE_W)) req_if ();
    cpr_rsp_if #(.PAGE_BITS(PAGE_W), .IDX_BITS(IDX_W)) rsp_if ();

    clock_page_replacement_core #(
        .SLOT_COUNT(SLOTS),
        .PAGE_BITS (PAGE_W)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if.sink),
        .o_rsp      (rsp_if.source),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow of the replacement store, the hand and the counters.
    // ------------------------------------------------------------------
    logic [PAGE_W-1:0] frame_page [SLOTS];
    logic              frame_used [SLOTS];
    logic              second_chance [SLOTS];
    int                hand;
    int                resident;
    logic [CNT_W-1:0]  hit_count;
    logic [CNT_W-1:0]  miss_count;
    logic [CFG_W-1:0]  capacity_reg;

    // Stimulus and scoreboard bookkeeping.
    logic [PAGE_W-1:0] page_q [$];
    t_page_result      pending_results [$];
    int                refs_queued = 0;
    int                req_count = 0;
    int                rsp_count = 0;
    int                fail_count = 0;
    int                evict_count = 0;
    int                settings_run = 0;
    int                idle_cycles = 0;
    bit                req_fired = 1'b0;
    bit                src_idle = 1'b1;
    bit                snk_idle = 1'b1;
    int                src_gap = 0;
    int                snk_hold = 0;
    bit                squeeze_done = 1'b0;

    // Out-of-range settings clamp: zero behaves as one, anything past the
    // built size behaves as the built size.
    function automatic int effective_capacity(logic [CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > SLOTS)
            return SLOTS;
        return int'(v);
    endfunction

    // Empty every slot and park the hand; the counters survive.
    function automatic void empty_store();
        for (int i = 0; i < SLOTS; i++) begin
            frame_page[i]    = '0;
            frame_used[i]    = 1'b0;
            second_chance[i] = 1'b0;
        end
        hand     = 0;
        resident = 0;
    endfunction

    // Apply one page reference to the shadow store and return its result.
    function automatic t_page_result clock_lookup(logic [PAGE_W-1:0] page);
        t_page_result r;
        int           cap;
        int           slot;
        int           guard;
        bit           found;
        r     = '0;
        cap   = effective_capacity(capacity_reg);
        slot  = 0;
        found = 1'b0;
        for (int i = 0; i < cap; i++) begin
            if (!found && frame_used[i] && frame_page[i] == page) begin
                found = 1'b1;
                slot  = i;
            end
        end
        if (hand >= cap)
            hand = 0;
        if (found) begin
            second_chance[slot] = 1'b1;
            if (hit_count != '1)
                hit_count++;
        end else begin
            if (resident >= cap) begin
                // Sweep: strip set bits until a clear one turns up. With every
                // bit set the hand goes once round and lands where it started.
                guard = 0;
                while (guard <= cap && second_chance[hand]) begin
                    second_chance[hand] = 1'b0;
                    hand = (hand + 1) % cap;
                    guard++;
                end
                if (frame_used[hand]) begin
                    r.evicted      = 1'b1;
                    r.evicted_page = frame_page[hand];
                    resident--;
                end
            end
            slot                = hand;
            frame_page[slot]    = page;
            frame_used[slot]    = 1'b1;
            second_chance[slot] = 1'b0;
            resident++;
            hand = (hand + 1) % cap;
            if (miss_count != '1)
                miss_count++;
        end
        r.hit    = found;
        r.slot   = IDX_W'(slot);
        r.hits   = hit_count;
        r.misses = miss_count;
        return r;
    endfunction

    // Mostly back to back, sometimes a short pause, now and then a long one.
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
            fail_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Request driver: change on the falling edge, hold while not taken.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n && (!req_if.valid || req_fired)) begin
            if (src_gap > 0) begin
                src_gap--;
                req_if.valid <= 1'b0;
            end else if (page_q.size() != 0) begin
                req_if.valid       <= 1'b1;
                req_if.page_number <= page_q.pop_front();
                // Draw the pause that follows this request once it is taken.
                if (src_idle)
                    src_gap = idle_gap();
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Response ready: random stalls, plus one long squeeze so the core
    // backs up and stops taking requests.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!squeeze_done && req_count >= SQUEEZE_AFTER) begin
                squeeze_done = 1'b1;
                snk_hold     = SQUEEZE_CYCLES;
            end
            if (snk_hold > 0) begin
                snk_hold--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
                if (snk_idle)
                    snk_hold = idle_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: sample on the rising edge, predict on each taken request,
    // check each taken response against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_page_result got;
        t_page_result want;
        bit           rsp_fire;
        if (i_rst_n) begin
            rsp_fire  = rsp_if.valid && rsp_if.ready;
            req_fired = req_if.valid && req_if.ready;
            if (rsp_fire) begin
                rsp_count++;
                got.hit          = rsp_if.hit;
                got.slot         = rsp_if.slot_index;
                got.evicted      = rsp_if.evicted;
                got.evicted_page = rsp_if.evicted_page;
                got.hits         = rsp_if.hits_so_far;
                got.misses       = rsp_if.misses_so_far;
                if (pending_results.size() == 0) begin
                    $error("response with no request outstanding");
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("hit", 32'(want.hit), 32'(got.hit));
                    check_field("slot_index", 32'(want.slot), 32'(got.slot));
                    check_field("evicted", 32'(want.evicted), 32'(got.evicted));
                    check_field("evicted_page", want.evicted_page, got.evicted_page);
                    check_field("hits_so_far", want.hits, got.hits);
                    check_field("misses_so_far", want.misses, got.misses);
                end
            end
            if (req_fired) begin
                want = clock_lookup(req_if.page_number);
                if (want.evicted)
                    evict_count++;
                pending_results.push_back(want);
                req_count++;
            end
            // Watchdog: give up if nothing moves on either channel for too long.
            if (rsp_fire || req_fired) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("timeout: no request or response moved for %0d cycles",
                             WATCHDOG_LIMIT);
                    $display("clock_page_replacement_core: mismatch");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequencing.
    // ------------------------------------------------------------------
    task automatic push_ref(logic [PAGE_W-1:0] page);
        page_q.push_back(page);
        refs_queued++;
    endtask

    // Wait until every queued reference has produced its response, then wait
    // out the drain margin so the core is surely idle.
    task automatic drain();
        while (rsp_count < refs_queued)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Drain, then write the capacity register; the write empties the store.
    task automatic set_capacity(logic [CFG_W-1:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        capacity_reg = v;
        empty_store();
        settings_run++;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Random references for one capacity setting. Draw mostly from a working
    // set of capacity to 2*capacity+2 pages so hits, full sweeps and evictions
    // all happen, with some cyclic scans and stray pages mixed in.
    task automatic random_phase(logic [CFG_W-1:0] v, int n);
        logic [PAGE_W-1:0] pool [$];
        int                cap;
        int                pool_len;
        int                done;
        int                r;
        cap      = effective_capacity(v);
        pool_len = cap + $urandom_range(0, cap + 2);
        for (int i = 0; i < pool_len; i++)
            pool.push_back($urandom());
        set_capacity(v);
        done = 0;
        while (done < n) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                // Cyclic scan over the working set.
                for (int i = 0; i < pool_len && done < n; i++) begin
                    push_ref(pool[i]);
                    done++;
                end
            end else begin
                if (r < 82)
                    push_ref(pool[$urandom_range(0, pool_len - 1)]);
                else if (r < 90)
                    push_ref($urandom());
                else if (r < 93)
                    push_ref('0);
                else if (r < 96)
                    push_ref('1);
                else if (r < 98)
                    push_ref(PAGE_W'(1) << $urandom_range(0, PAGE_W - 1));
                else
                    push_ref(~(PAGE_W'(1) << $urandom_range(0, PAGE_W - 1)));
                done++;
            end
        end
    endtask

    initial begin
        logic [CFG_W-1:0] settings [12];
        settings = '{5'd31, 5'd1, 5'd3, 5'd16, 5'd0, 5'd8, 5'd2, 5'd15,
                     5'd17, 5'd5, 5'd16, 5'd12};

        // Shadow state at reset: default capacity, empty store, zero counters.
        capacity_reg = CFG_RESET;
        hit_count    = '0;
        miss_count   = '0;
        empty_store();

        req_if.valid       = 1'b0;
        req_if.page_number = '0;
        rsp_if.ready       = 1'b0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extreme page numbers, hits and misses at reset capacity.
        push_ref('0);
        push_ref('1);
        push_ref('0);
        push_ref('1);
        push_ref(32'h8000_0000);
        push_ref(32'h0000_0001);
        push_ref(32'hAAAA_AAAA);
        push_ref(32'h5555_5555);

        // Capacity zero acts as one slot: every new page after the first evicts the last.
        set_capacity(5'd0);
        push_ref(32'h0000_0007);
        push_ref(32'h0000_0007);
        push_ref(32'h0000_0009);
        push_ref(32'h0000_0007);

        // Two slots: one second chance spent, then every bit set so the hand
        // goes all the way round before it evicts.
        set_capacity(5'd2);
        push_ref(32'h0000_00A0);
        push_ref(32'h0000_00B0);
        push_ref(32'h0000_00A0);
        push_ref(32'h0000_00C0);
        push_ref(32'h0000_00A0);
        push_ref(32'h0000_00C0);
        push_ref(32'h0000_00D0);

        // Rewrite keeps the counters but empties the store: old pages miss.
        set_capacity(5'd4);
        push_ref(32'h0000_00D0);
        push_ref(32'h0000_00A0);

        // Random phases over a spread of settings, idling switched per phase;
        // the fourth runs flat out on both sides.
        for (int p = 0; p < 12; p++) begin
            src_idle = (p == 3) ? 1'b0 : ($urandom_range(0, 3) != 0);
            snk_idle = (p == 3) ? 1'b0 : ($urandom_range(0, 3) != 0);
            random_phase(settings[p], 152);
        end

        drain();
        if (pending_results.size() != 0) begin
            $error("%0d expected responses never arrived", pending_results.size());
            fail_count++;
        end

        $display("%0d page references over %0d capacity writes: %0d hits, %0d misses",
                 rsp_count, settings_run, hit_count, miss_count);
        $display("%0d evictions predicted; output held off for %0d cycles once",
                 evict_count, SQUEEZE_CYCLES);
        if (fail_count == 0)
            $display("clock_page_replacement_core: match");
        else
            $display("clock_page_replacement_core: mismatch");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/cpr_pkg.sv
sv/cpr_ifs.sv
sv/cpr_ctrl.sv
sv/cpr_dpath.sv
sv/clock_page_replacement_core.sv
sv/cpr_checker.sv
dv/tb_top.sv
